// ----- rtl/tofb_pkg.sv -----
// Package for the text overlay framebuffer: sizes, action codes, register map, cell type.
// No dependencies; used by tofb_ram and text_overlay_dirty_framebuffer.
`default_nettype none
package tofb_pkg;
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 32;

	localparam logic [7:0] SPACE_CODE = 8'h20;

	localparam logic [2:0] ACT_WRITE      = 3'd0;
	localparam logic [2:0] ACT_CLEAR      = 3'd1;
	localparam logic [2:0] ACT_MARK_ALL   = 3'd2;
	localparam logic [2:0] ACT_MARK_BLINK = 3'd3;
	localparam logic [2:0] ACT_DRAIN      = 3'd4;

	localparam logic [1:0] REG_COLS  = 2'd0;
	localparam logic [1:0] REG_ROWS  = 2'd1;
	localparam logic [1:0] REG_MODE  = 2'd2;
	localparam logic [1:0] REG_BLINK = 2'd3;

	localparam logic [6:0] RST_COLS  = 7'd30;
	localparam logic [5:0] RST_ROWS  = 6'd16;
	localparam logic [7:0] RST_BLINK = 8'd1;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] chr;
	} cell_t;
endpackage
`default_nettype wire

// ----- rtl/tofb_ram.sv -----
// Character cell store: single port RAM, registered read every cycle.
// Depends on tofb_pkg for cell_t.
`default_nettype none
module tofb_ram
	import tofb_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire cell_t         wdata,
	output cell_t              rdata
);
	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/text_overlay_dirty_framebuffer.sv -----
// Top level of the text overlay framebuffer: APB registers, sequencer, dirty bitmaps.
// Depends on tofb_pkg and tofb_ram.
//
// Character-cell screen store with a dirty bitmap per row. One item is worked at a
// time; in_ready is high only when the sequencer is idle. After reset and after each
// clear action the store is swept, one cell per cycle, over all MAX_COLS*MAX_ROWS cells
// (2048 by default) before the next item is taken. A cell write checks the bounds,
// reads the cell and writes it back only if it changed. A mark reads every active
// cell through the single RAM port, row by row. A drain skips clean rows, finds the
// first dirty column, then reads each emitted character and waits for the handshake.
`default_nettype none
module text_overlay_dirty_framebuffer
	import tofb_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  action,
	input  wire logic [5:0]  cell_col,
	input  wire logic [4:0]  cell_row,
	input  wire logic [7:0]  cell_attr,
	input  wire logic [7:0]  cell_char,
	input  wire logic [6:0]  room,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [4:0]  out_row,
	output logic      [5:0]  out_col,
	output logic      [7:0]  out_attr,
	output logic      [7:0]  out_char,
	output logic             run_last,
	output logic             all_drained
);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CIW   = $clog2(MAX_COLS);
	localparam int RIW   = $clog2(MAX_ROWS);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_WCHK, S_WWAIT, S_WCMP, S_MROW, S_MWAIT, S_MEV,
		S_DSCAN, S_DFIND, S_DNEXT, S_DWAIT, S_DEV, S_DOWAIT, S_DEND, S_OWAIT
	} state_t;

	state_t state_q;

	logic [6:0] cols_q;
	logic [5:0] rows_q;
	logic       mode_q;
	logic [7:0] blink_mask_q;

	logic [MAX_COLS-1:0] dirty_q [MAX_ROWS];
	logic                any_dirty_q;
	logic [6:0]          scan_q;
	logic                phase_q;

	logic [2:0]  act_q;
	logic [5:0]  x_q;
	logic [4:0]  y_q;
	logic [7:0]  attr_in_q;
	logic [7:0]  char_in_q;
	logic [6:0]  room_q;

	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       base_q;
	logic [6:0]          r_q;
	logic [6:0]          c_q;
	logic [6:0]          n_q;
	logic [MAX_COLS-1:0] m_q;
	logic [7:0]          run_attr_q;
	logic                blank_q;
	logic [6:0]          pend_col_q;
	logic [7:0]          pend_char_q;

	logic [4:0] out_row_q;
	logic [5:0] out_col_q;
	logic [7:0] out_attr_q;
	logic [7:0] out_char_q;
	logic       run_last_q;
	logic       drained_q;
	logic       out_valid_q;

	logic [6:0]          cols_eff;
	logic [6:0]          rows_eff;
	logic [MAX_COLS-1:0] col_mask;
	logic [MAX_COLS-1:0] scan_bits;
	logic                ram_we;
	cell_t               ram_wdata;
	cell_t               ram_rdata;
	logic                cell_hit;
	logic                blank_now;
	logic                cfg_wr;

	assign cols_eff = (cols_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_q;
	assign rows_eff = ({1'b0, rows_q} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {1'b0, rows_q};

	always_comb begin
		for (int i = 0; i < MAX_COLS; i++) begin
			col_mask[i] = (7'(i) < cols_eff);
		end
	end

	assign scan_bits = dirty_q[RIW'(scan_q)] & col_mask;

	// mark-blink only counts cells whose attribute meets the blink mask
	assign cell_hit = (ram_rdata.chr != SPACE_CODE) &&
		((act_q != ACT_MARK_BLINK) || ((ram_rdata.attr & blink_mask_q) != 8'd0));
	assign blank_now = (n_q == 7'd0) ?
		(mode_q && ((ram_rdata.attr & blink_mask_q) != 8'd0) && phase_q) : blank_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '{attr: 8'd0, chr: SPACE_CODE};
		if (state_q == S_CLR) begin
			ram_we = 1'b1;
		end else if (state_q == S_WCMP &&
				(ram_rdata.chr != char_in_q || ram_rdata.attr != attr_in_q)) begin
			ram_we    = 1'b1;
			ram_wdata = '{attr: attr_in_q, chr: char_in_q};
		end
	end

	tofb_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (addr_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// APB registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q       <= RST_COLS;
			rows_q       <= RST_ROWS;
			mode_q       <= 1'b0;
			blink_mask_q <= RST_BLINK;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_COLS:  cols_q       <= pwdata[6:0];
				REG_ROWS:  rows_q       <= pwdata[5:0];
				REG_MODE:  mode_q       <= pwdata[0];
				REG_BLINK: blink_mask_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_COLS:  prdata = {25'd0, cols_q};
			REG_ROWS:  prdata = {26'd0, rows_q};
			REG_MODE:  prdata = {31'd0, mode_q};
			REG_BLINK: prdata = {24'd0, blink_mask_q};
			default:   prdata = 32'd0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			addr_q      <= '0;
			any_dirty_q <= 1'b0;
			scan_q      <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_ROWS; i++) begin
				dirty_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						act_q     <= action;
						x_q       <= cell_col;
						y_q       <= cell_row;
						attr_in_q <= cell_attr;
						char_in_q <= cell_char;
						room_q    <= room;
						case (action) inside
							ACT_WRITE: state_q <= S_WCHK;
							ACT_CLEAR: begin
								for (int i = 0; i < MAX_ROWS; i++) begin
									dirty_q[i] <= '0;
								end
								any_dirty_q <= 1'b0;
								addr_q      <= '0;
								state_q     <= S_CLR;
							end
							ACT_MARK_ALL, ACT_MARK_BLINK: begin
								r_q     <= '0;
								c_q     <= '0;
								m_q     <= '0;
								addr_q  <= '0;
								state_q <= S_MROW;
							end
							ACT_DRAIN: state_q <= any_dirty_q ? S_DSCAN : S_IDLE;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_WCHK: begin
					if ({1'b0, x_q} < cols_eff && {2'b0, y_q} < rows_eff) begin
						addr_q  <= AW'(y_q) * AW'(cols_eff) + AW'(x_q);
						state_q <= S_WWAIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WWAIT: state_q <= S_WCMP;
				S_WCMP: begin
					if (ram_we) begin
						dirty_q[RIW'(y_q)][CIW'(x_q)] <= 1'b1;
						any_dirty_q                   <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_MROW: begin
					if (r_q >= rows_eff) begin
						if (act_q == ACT_MARK_BLINK) begin
							phase_q <= !phase_q;
						end
						state_q <= S_IDLE;
					end else if (c_q >= cols_eff) begin
						if (act_q == ACT_MARK_BLINK) begin
							dirty_q[RIW'(r_q)] <= dirty_q[RIW'(r_q)] | m_q;
						end else begin
							dirty_q[RIW'(r_q)] <= m_q;
						end
						if (m_q != '0) begin
							any_dirty_q <= 1'b1;
						end
						r_q <= r_q + 7'd1;
						c_q <= '0;
						m_q <= '0;
					end else begin
						state_q <= S_MWAIT;
					end
				end
				S_MWAIT: state_q <= S_MEV;
				S_MEV: begin
					m_q[CIW'(c_q)] <= cell_hit;
					c_q            <= c_q + 7'd1;
					addr_q         <= addr_q + AW'(1);
					state_q        <= S_MROW;
				end
				S_DSCAN: begin
					if (scan_q >= rows_eff) begin
						out_row_q   <= '0;
						out_col_q   <= '0;
						out_attr_q  <= '0;
						out_char_q  <= '0;
						run_last_q  <= 1'b0;
						drained_q   <= 1'b1;
						out_valid_q <= 1'b1;
						scan_q      <= '0;
						any_dirty_q <= 1'b0;
						state_q     <= S_OWAIT;
					end else if (scan_bits == '0) begin
						scan_q <= scan_q + 7'd1;
					end else if (room_q == 7'd0) begin
						state_q <= S_IDLE;
					end else begin
						m_q     <= scan_bits;
						base_q  <= AW'(scan_q) * AW'(cols_eff);
						c_q     <= '0;
						n_q     <= '0;
						state_q <= S_DFIND;
					end
				end
				S_DFIND: begin
					if (m_q[CIW'(c_q)]) begin
						addr_q  <= base_q + AW'(c_q);
						state_q <= S_DWAIT;
					end else begin
						c_q <= c_q + 7'd1;
					end
				end
				S_DNEXT: begin
					if (c_q < cols_eff && n_q < room_q && m_q[CIW'(c_q)]) begin
						addr_q  <= base_q + AW'(c_q);
						state_q <= S_DWAIT;
					end else begin
						state_q <= S_DEND;
					end
				end
				S_DWAIT: state_q <= S_DEV;
				S_DEV: begin
					if (n_q == 7'd0 || ram_rdata.attr == run_attr_q) begin
						if (n_q == 7'd0) begin
							run_attr_q <= ram_rdata.attr;
							blank_q    <= blank_now;
							state_q    <= S_DNEXT;
						end else begin
							// previous beat continues the run
							out_row_q   <= 5'(scan_q);
							out_col_q   <= 6'(pend_col_q);
							out_attr_q  <= run_attr_q;
							out_char_q  <= pend_char_q;
							run_last_q  <= 1'b0;
							drained_q   <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= S_DOWAIT;
						end
						pend_col_q  <= c_q;
						pend_char_q <= blank_now ? SPACE_CODE : ram_rdata.chr;
						dirty_q[RIW'(scan_q)][CIW'(c_q)] <= 1'b0;
						n_q <= n_q + 7'd1;
						c_q <= c_q + 7'd1;
					end else begin
						state_q <= S_DEND;
					end
				end
				S_DOWAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_DNEXT;
					end
				end
				S_DEND: begin
					out_row_q   <= 5'(scan_q);
					out_col_q   <= 6'(pend_col_q);
					out_attr_q  <= run_attr_q;
					out_char_q  <= pend_char_q;
					run_last_q  <= 1'b1;
					drained_q   <= 1'b0;
					out_valid_q <= 1'b1;
					if (scan_bits == '0) begin
						scan_q <= scan_q + 7'd1;
					end
					state_q <= S_OWAIT;
				end
				S_OWAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign out_attr    = out_attr_q;
	assign out_char    = out_char_q;
	assign run_last    = run_last_q;
	assign all_drained = drained_q;

	a_idle_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result beat is pending");

	a_flush_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && all_drained) |-> (out_row == 5'd0 && out_col == 6'd0 &&
			out_attr == 8'd0 && out_char == 8'd0 && !run_last))
		else $error("flush beat carries nonzero fields");

	a_clear_drops_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_CLEAR) |=> !any_dirty_q)
		else $error("dirty flag survived a clear");
endmodule
`default_nettype wire

// ----- tb/sv/text_overlay_dirty_framebuffer_test.sv -----
// Testbench for text_overlay_dirty_framebuffer: directed table plus random actions,
// every beat checked against an in-bench screen and dirty-bitmap predictor or a table beat.
// Depends on tofb_pkg and the RTL of text_overlay_dirty_framebuffer.
`default_nettype none
module text_overlay_dirty_framebuffer_test;
	import tofb_pkg::*;

	typedef struct {
		logic [4:0] row;
		logic [5:0] col;
		logic [7:0] attr;
		logic [7:0] chr;
		logic       last;
		logic       drained;
	} beat_t;

	typedef struct {
		logic [2:0] act;
		logic [5:0] col;
		logic [4:0] row;
		logic [7:0] attr;
		logic [7:0] chr;
		logic [6:0] room;
		bit         typed;
		beat_t      want;
	} cmd_t;

	logic clk = 0, arst_n = 0;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] action;
	logic [5:0] cell_col;
	logic [4:0] cell_row;
	logic [7:0] cell_attr, cell_char;
	logic [6:0] room;
	logic [4:0] out_row;
	logic [5:0] out_col;
	logic [7:0] out_attr, out_char;
	logic run_last, all_drained;

	text_overlay_dirty_framebuffer u_dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// screen predictor state
	logic [7:0] scr_char [2048];
	logic [7:0] scr_attr [2048];
	logic [63:0] row_dirty [32];
	bit any_dirty, blink_hidden;
	int scan_row;
	logic [6:0] r_cols;
	logic [5:0] r_rows;
	logic r_mode;
	logic [7:0] r_mask;

	beat_t pending_beats [$];
	cmd_t directed [$];
	int errors = 0, n_items = 0, n_beats = 0, n_flush = 0;
	bit quiet = 0, hold_req = 0;

	function automatic int cols_used();
		return r_cols > 64 ? 64 : r_cols;
	endfunction

	function automatic int rows_used();
		return r_rows > 32 ? 32 : r_rows;
	endfunction

	function automatic void mark_screen(bit blink_only);
		int ec, er, a;
		logic [63:0] m;
		ec = cols_used();
		er = rows_used();
		for (int r = 0; r < er; r++) begin
			m = 0;
			for (int c = 0; c < ec; c++) begin
				a = r * ec + c;
				if (scr_char[a] != SPACE_CODE && (!blink_only || (scr_attr[a] & r_mask) != 0))
					m[c] = 1;
			end
			row_dirty[r] = blink_only ? (row_dirty[r] | m) : m;
			if (m != 0)
				any_dirty = 1;
		end
	endfunction

	// returns the beats one action produces and updates the screen state
	function automatic void predict_action(cmd_t it, ref beat_t outq[$]);
		int ec, er, a, c, n, base;
		logic [63:0] cm, m;
		logic [7:0] at;
		bit blank;
		beat_t b;
		ec = cols_used();
		er = rows_used();
		cm = ec >= 64 ? '1 : ((64'd1 << ec) - 1);
		case (it.act)
			ACT_WRITE: begin
				if (it.col < ec && it.row < er) begin
					a = it.row * ec + it.col;
					if (scr_char[a] != it.chr || scr_attr[a] != it.attr) begin
						scr_char[a] = it.chr;
						scr_attr[a] = it.attr;
						row_dirty[it.row][it.col] = 1;
						any_dirty = 1;
					end
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < 2048; i++) begin
					scr_char[i] = SPACE_CODE;
					scr_attr[i] = 0;
				end
				for (int i = 0; i < 32; i++)
					row_dirty[i] = 0;
				any_dirty = 0;
			end
			ACT_MARK_ALL: mark_screen(0);
			ACT_MARK_BLINK: begin
				mark_screen(1);
				blink_hidden = !blink_hidden;
			end
			ACT_DRAIN: begin
				if (any_dirty) begin
					while (scan_row < er && (row_dirty[scan_row] & cm) == 0)
						scan_row++;
					if (scan_row >= er) begin
						b = '{default: 0};
						b.drained = 1;
						outq.push_back(b);
						scan_row = 0;
						any_dirty = 0;
					end else if (it.room != 0) begin
						m = row_dirty[scan_row] & cm;
						c = 0;
						while (!m[c])
							c++;
						base = scan_row * ec;
						at = scr_attr[base + c];
						blank = r_mode && (at & r_mask) != 0 && blink_hidden;
						n = 0;
						while (c < ec && n < it.room && m[c] && scr_attr[base + c] == at) begin
							b.row = scan_row[4:0];
							b.col = c[5:0];
							b.attr = at;
							b.chr = blank ? SPACE_CODE : scr_char[base + c];
							b.last = 0;
							b.drained = 0;
							outq.push_back(b);
							row_dirty[scan_row][c] = 0;
							n++;
							c++;
						end
						outq[outq.size() - 1].last = 1;
						if ((row_dirty[scan_row] & cm) == 0)
							scan_row++;
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic add_row(input logic [2:0] act, input int col, input int row,
			input int attr, input int chr, input int rm, input bit typed = 0,
			input beat_t want = '{default: 0});
		cmd_t t;
		t.act = act;
		t.col = 6'(col);
		t.row = 5'(row);
		t.attr = 8'(attr);
		t.chr = 8'(chr);
		t.room = 7'(rm);
		t.typed = typed;
		t.want = want;
		directed.push_back(t);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		case (idx)
			REG_COLS:  r_cols = val[6:0];
			REG_ROWS:  r_rows = val[5:0];
			REG_MODE:  r_mode = val[0];
			REG_BLINK: r_mask = val[7:0];
		endcase
	endtask

	task automatic send(input cmd_t it);
		beat_t got [$];
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		action <= it.act;
		cell_col <= it.col;
		cell_row <= it.row;
		cell_attr <= it.attr;
		cell_char <= it.chr;
		room <= it.room;
		do @(posedge clk); while (!in_ready);
		predict_action(it, got);
		if (it.typed)
			pending_beats.push_back(it.want);
		else
			foreach (got[i]) pending_beats.push_back(got[i]);
		n_items++;
	endtask

	// block may still be sweeping or marking after the last beat
	task automatic settle();
		in_valid <= 0;
		wait (pending_beats.size() == 0);
		repeat (7000) @(posedge clk);
	endtask

	function automatic cmd_t random_cmd();
		cmd_t t;
		int p, ec, er;
		ec = cols_used();
		er = rows_used();
		t = '{default: 0};
		p = $urandom_range(0, 99);
		if (p < 55) t.act = ACT_WRITE;
		else if (p < 87) t.act = ACT_DRAIN;
		else if (p < 92) t.act = ACT_MARK_ALL;
		else if (p < 96) t.act = ACT_MARK_BLINK;
		else if (p < 98) t.act = ACT_CLEAR;
		else t.act = 3'($urandom_range(5, 7));
		if (ec > 0 && er > 0 && $urandom_range(0, 9) != 0) begin
			t.col = 6'($urandom_range(0, ec - 1));
			t.row = 5'($urandom_range(0, er - 1));
		end else begin
			t.col = 6'($urandom_range(0, 63));
			t.row = 5'($urandom_range(0, 31));
		end
		// few attributes so runs of equal attribute form
		t.attr = $urandom_range(0, 3) != 0 ?
			(($urandom_range(0, 1) != 0 ? 8'h81 : 8'h00) | 8'($urandom_range(0, 1))) :
			8'($urandom_range(0, 255));
		t.chr = $urandom_range(0, 7) == 0 ? SPACE_CODE : 8'($urandom_range(0, 255));
		p = $urandom_range(0, 9);
		t.room = p < 7 ? 7'($urandom_range(0, 8)) :
			(p < 9 ? 7'd64 : 7'($urandom_range(0, 127)));
		return t;
	endfunction

	task automatic chk(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		beat_t w;
		if (arst_n && out_valid && out_ready) begin
			n_beats++;
			if (all_drained)
				n_flush++;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual row %0d col %0d", $time,
					out_row, out_col);
				errors++;
			end else begin
				w = pending_beats.pop_front();
				chk("out_row", w.row, out_row);
				chk("out_col", w.col, out_col);
				chk("out_attr", w.attr, out_attr);
				chk("out_char", w.chr, out_char);
				chk("run_last", w.last, run_last);
				chk("all_drained", w.drained, all_drained);
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		out_ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (quiet) begin
				out_ready <= 1;
			end else begin
				out_ready <= $urandom_range(0, 3) != 0;
				repeat ($urandom_range(0, 15)) @(posedge clk);
			end
		end
	end

	initial begin
		#40000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		beat_t b;
		cmd_t t;
		int n_rand;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= 0;
		pwdata <= 0;
		in_valid <= 0;
		action <= ACT_WRITE;
		cell_col <= 0;
		cell_row <= 0;
		cell_attr <= 0;
		cell_char <= 0;
		room <= 0;
		for (int i = 0; i < 2048; i++) begin
			scr_char[i] = SPACE_CODE;
			scr_attr[i] = 0;
		end
		for (int i = 0; i < 32; i++)
			row_dirty[i] = 0;
		any_dirty = 0;
		blink_hidden = 0;
		scan_row = 0;
		r_cols = RST_COLS;
		r_rows = RST_ROWS;
		r_mode = 0;
		r_mask = RST_BLINK;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table at reset sizes
		add_row(ACT_DRAIN, 0, 0, 0, 0, 5);           // nothing dirty
		add_row(ACT_WRITE, 0, 0, 0, 8'h41, 0);
		add_row(ACT_WRITE, 0, 0, 0, 8'h41, 0);       // same cell, ignored
		add_row(ACT_WRITE, 30, 0, 1, 8'h42, 0);      // past last column
		add_row(ACT_WRITE, 63, 31, 255, 255, 0);     // past both limits
		add_row(ACT_DRAIN, 0, 0, 0, 0, 0);           // room zero
		b = '{row: 0, col: 0, attr: 0, chr: 8'h41, last: 1, drained: 0};
		add_row(ACT_DRAIN, 0, 0, 0, 0, 1, 1, b);
		b = '{default: 0};
		b.drained = 1;
		add_row(ACT_DRAIN, 0, 0, 0, 0, 4, 1, b);     // flush
		add_row(ACT_WRITE, 1, 2, 1, 8'h42, 0);
		add_row(ACT_WRITE, 2, 2, 1, 8'h43, 0);
		add_row(ACT_WRITE, 3, 2, 2, 8'h44, 0);
		add_row(ACT_DRAIN, 0, 0, 0, 0, 64);
		add_row(ACT_DRAIN, 0, 0, 0, 0, 127);
		add_row(ACT_DRAIN, 0, 0, 0, 0, 127, 1, b);
		add_row(ACT_MARK_ALL, 0, 0, 0, 0, 0);
		add_row(ACT_DRAIN, 0, 0, 0, 0, 127);
		add_row(ACT_MARK_BLINK, 0, 0, 0, 0, 0);
		add_row(ACT_CLEAR, 0, 0, 0, 0, 0);
		add_row(ACT_DRAIN, 0, 0, 0, 0, 3);
		add_row(3'd5, 0, 0, 0, 0, 0);
		add_row(3'd6, 63, 31, 255, 255, 127);
		add_row(3'd7, 0, 0, 0, 0, 0);
		add_row(ACT_WRITE, 29, 15, 255, 0, 0);
		add_row(ACT_MARK_BLINK, 0, 0, 0, 0, 0);
		add_row(ACT_DRAIN, 0, 0, 0, 0, 2);
		foreach (directed[i]) send(directed[i]);
		settle();

		// random phases over several register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_COLS, 64); reg_write(REG_ROWS, 32);
					reg_write(REG_MODE, 1); reg_write(REG_BLINK, 8'h80);
					n_rand = 40;
				end
				1: begin
					reg_write(REG_COLS, 1); reg_write(REG_ROWS, 1);
					reg_write(REG_BLINK, 8'hFF);
					n_rand = 20;
				end
				2: begin
					reg_write(REG_COLS, 127); reg_write(REG_ROWS, 63);
					reg_write(REG_BLINK, 8'h01);
					n_rand = 25;
				end
				3: begin
					reg_write(REG_COLS, 0); reg_write(REG_ROWS, 0);
					reg_write(REG_MODE, 0); reg_write(REG_BLINK, 0);
					n_rand = 10;
				end
				default: begin
					reg_write(REG_COLS, 8); reg_write(REG_ROWS, 4);
					reg_write(REG_MODE, 1); reg_write(REG_BLINK, 8'h03);
					n_rand = 40;
				end
			endcase
			for (int i = 0; i < n_rand; i++) begin
				if (ph == 0 && i == 20)
					hold_req = 1;
				if (ph == 2 && i == 15) begin
					in_valid <= 0;
					wait (pending_beats.size() == 0);
					@(posedge clk);
				end
				if (ph == 4 && i == 30)
					quiet = 1;
				t = random_cmd();
				send(t);
			end
			// drain what is left so the next phase starts from known counts
			for (int k = 0; k < 4; k++) begin
				t = '{default: 0};
				t.act = ACT_DRAIN;
				t.room = 64;
				send(t);
			end
			settle();
		end

		$display("%0d actions sent, %0d beats checked (%0d flush beats)", n_items, n_beats,
			n_flush);
		$display("sizes from 0 to oversized, blink blanking on and off, stalls on both sides");
		if (errors == 0 && pending_beats.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
